// ===== hdl/tpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, codes and constants of the tape pulse generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // tape store geometry
  localparam int STORE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int LEN_W   = 17;
  localparam int TICK_W  = 16;
  localparam int PHASE_W = 3;
  localparam int REQ_W   = 2;
  localparam int CIDX_W  = 3;
  localparam int PILOT_W = 15;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_STOP   = 2'd3;

  // playback phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PILOT = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SYNC1 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SYNC2 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BIT_A = 3'd4;
  localparam logic [PHASE_W-1:0] PH_BIT_B = 3'd5;
  localparam logic [PHASE_W-1:0] PH_PAUSE = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd7;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_TAPE_LEN  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PILOT     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SYNC1     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SYNC2     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_ZERO      = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ONE       = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_PAUSE     = 3'd6;

  // register reset values
  localparam logic [TICK_W-1:0] RST_PILOT = 16'd43360;
  localparam logic [TICK_W-1:0] RST_SYNC1 = 16'd13340;
  localparam logic [TICK_W-1:0] RST_SYNC2 = 16'd14700;
  localparam logic [TICK_W-1:0] RST_ZERO  = 16'd17100;
  localparam logic [TICK_W-1:0] RST_ONE   = 16'd34200;
  localparam logic [TICK_W-1:0] RST_PAUSE = 16'd1660;

  // pilot lengths in halves: header block (flag byte zero) and data block
  localparam logic [PILOT_W-1:0] HDR_HALVES = 15'd16128;
  localparam logic [PILOT_W-1:0] DAT_HALVES = 15'd6440;

  localparam logic [7:0] MASK_FIRST = 8'h80;
  localparam logic [7:0] FLAG_HDR   = 8'h00;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [LEN_W-1:0]  eff_len;
    logic [TICK_W-1:0] pilot;
    logic [TICK_W-1:0] sync1;
    logic [TICK_W-1:0] sync2;
    logic [TICK_W-1:0] zero_bit;
    logic [TICK_W-1:0] one_bit;
    logic [TICK_W-1:0] pause;
  } cfg_t;

  // store access from the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // one result transaction
  typedef struct packed {
    logic               start_failed;
    logic               running;
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  period;
    logic               armed;
    logic               ear;
  } res_t;

endpackage

// ===== hdl/tap_tape_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// tap_tape_pulse_generator
// Tape image player: byte store plus half-pulse sequencer, one result per
// request.
// ----------------------------------------------------------------------------
// Each input transaction gives exactly one result transaction. A store write,
// a stop, an ignored expiry and most expiries go from acceptance straight to
// the result register; an expiry that needs the next data byte first passes
// the fetch state, and a start or the end of a pause, which reads the block
// length and flag byte, passes the load, length and check states and, for a
// non-empty block, the flag state. The request sequencer handles one request
// at a time and reads the tape store through its single registered read port.
// The result register lets the next request be accepted while a result waits
// downstream. The store has no reset; no clearing pass runs. Configuration writes are taken on any cycle.
module tap_tape_pulse_generator (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], data[23:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // ear_level[0], armed[1], period_ticks[17:2],
                                  // phase[20:18], running[21], start_failed[22]
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  tpg_pkg::cfg_t     cfg;
  tpg_pkg::mem_req_t mem;
  tpg_pkg::res_t     res;
  logic [7:0]        rd_data;
  logic              res_valid;
  logic              res_take;
  logic              out_valid_r;
  tpg_pkg::res_t     out_res_r;

  tpg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpg_store u_store (
    .clk     (clk),
    .req     (mem),
    .rd_data (rd_data)
  );

  tpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_type   (in_tuser),
    .in_addr   (in_tdata[15:0]),
    .in_data   (in_tdata[23:16]),
    .cfg       (cfg),
    .mem       (mem),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  // result packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.start_failed, out_res_r.running,
                       out_res_r.phase, out_res_r.period, out_res_r.armed,
                       out_res_r.ear};

endmodule

// ===== hdl/tpg_regs.sv =====
// ----------------------------------------------------------------------------
// tpg_regs
// Configuration registers, written through the cfg channel.
// ----------------------------------------------------------------------------
module tpg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tpg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [tpg_pkg::LEN_W-1:0]   cfg_data,
  output tpg_pkg::cfg_t               cfg
);

  logic [tpg_pkg::LEN_W-1:0]  tape_len_r;
  logic [tpg_pkg::TICK_W-1:0] pilot_r;
  logic [tpg_pkg::TICK_W-1:0] sync1_r;
  logic [tpg_pkg::TICK_W-1:0] sync2_r;
  logic [tpg_pkg::TICK_W-1:0] zero_r;
  logic [tpg_pkg::TICK_W-1:0] one_r;
  logic [tpg_pkg::TICK_W-1:0] pause_r;
  logic [tpg_pkg::TICK_W-1:0] v16;

  assign cfg_ready = 1'b1;
  assign v16       = cfg_data[tpg_pkg::TICK_W-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tape_len_r <= '0;
      pilot_r    <= tpg_pkg::RST_PILOT;
      sync1_r    <= tpg_pkg::RST_SYNC1;
      sync2_r    <= tpg_pkg::RST_SYNC2;
      zero_r     <= tpg_pkg::RST_ZERO;
      one_r      <= tpg_pkg::RST_ONE;
      pause_r    <= tpg_pkg::RST_PAUSE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tpg_pkg::CFG_TAPE_LEN: tape_len_r <= cfg_data;
        tpg_pkg::CFG_PILOT:    pilot_r    <= v16;
        tpg_pkg::CFG_SYNC1:    sync1_r    <= v16;
        tpg_pkg::CFG_SYNC2:    sync2_r    <= v16;
        tpg_pkg::CFG_ZERO:     zero_r     <= v16;
        tpg_pkg::CFG_ONE:      one_r      <= v16;
        tpg_pkg::CFG_PAUSE:    pause_r    <= v16;
        default: ;
      endcase
    end
  end

  // tape length clipped to the store size
  always_comb begin
    cfg.eff_len  = (tape_len_r > tpg_pkg::LEN_W'(tpg_pkg::STORE_DEPTH)) ?
                   tpg_pkg::LEN_W'(tpg_pkg::STORE_DEPTH) : tape_len_r;
    cfg.pilot    = pilot_r;
    cfg.sync1    = sync1_r;
    cfg.sync2    = sync2_r;
    cfg.zero_bit = zero_r;
    cfg.one_bit  = one_r;
    cfg.pause    = pause_r;
  end

endmodule

// ===== hdl/tpg_store.sv =====
// ----------------------------------------------------------------------------
// tpg_store
// Tape byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpg_store (
  input  logic              clk,
  input  tpg_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [tpg_pkg::STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ===== hdl/tpg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpg_ctrl
// Request sequencer: reads the tape store, updates playback state and
// builds one result per request.
// ----------------------------------------------------------------------------
module tpg_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tpg_pkg::REQ_W-1:0]   in_type,
  input  logic [15:0]                 in_addr,
  input  logic [7:0]                  in_data,
  input  tpg_pkg::cfg_t               cfg,
  output tpg_pkg::mem_req_t           mem,
  input  logic [7:0]                  rd_data,
  output tpg_pkg::res_t               res,
  output logic                        res_valid,
  input  logic                        res_take
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_LEN_LO = 3'd2;
  localparam logic [2:0] S_LEN_HI = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_FLAG   = 3'd5;
  localparam logic [2:0] S_FETCH  = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  localparam int AW = tpg_pkg::ADDR_W;
  localparam int LW = tpg_pkg::LEN_W;

  logic [2:0]                   st_r, st_nxt;
  logic [LW-1:0]                pos_r, pos_nxt;
  logic [tpg_pkg::PILOT_W-1:0]  pilot_r, pilot_nxt;
  logic [15:0]                  bytes_r, bytes_nxt;
  logic [7:0]                   cur_r, cur_nxt;
  logic [7:0]                   mask_r, mask_nxt;
  logic [15:0]                  pause_r, pause_nxt;
  logic [tpg_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                         ear_r, ear_nxt;
  logic                         run_r, run_nxt;
  logic                         armed_r, armed_nxt;
  logic [tpg_pkg::TICK_W-1:0]   period_r, period_nxt;
  logic                         failed_r, failed_nxt;
  logic                         from_start_r, from_start_nxt;
  logic [7:0]                   lo_r, lo_nxt;
  logic [15:0]                  len_r, len_nxt;

  logic       accept;
  logic       load_ok;
  logic       load_bad;
  logic [7:0] mask_sh;
  logic [LW-1:0] pos_inc;

  assign in_ready  = (st_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (st_r == S_EMIT);
  assign pos_inc   = pos_r + LW'(1);
  assign mask_sh   = (phase_r == tpg_pkg::PH_BIT_B) ? (mask_r >> 1) : mask_r;

  // store access
  always_comb begin
    mem.wr_en   = accept && (in_type == tpg_pkg::REQ_WRITE) &&
                  ({1'b0, in_addr} < 17'(tpg_pkg::STORE_DEPTH));
    mem.wr_addr = in_addr[AW-1:0];
    mem.wr_data = in_data;
    mem.rd_addr = (st_r == S_LEN_LO) ? pos_inc[AW-1:0] : pos_r[AW-1:0];
  end

  // sequencer
  always_comb begin
    st_nxt         = st_r;
    pos_nxt        = pos_r;
    pilot_nxt      = pilot_r;
    bytes_nxt      = bytes_r;
    cur_nxt        = cur_r;
    mask_nxt       = mask_r;
    pause_nxt      = pause_r;
    phase_nxt      = phase_r;
    ear_nxt        = ear_r;
    run_nxt        = run_r;
    armed_nxt      = armed_r;
    period_nxt     = period_r;
    failed_nxt     = failed_r;
    from_start_nxt = from_start_r;
    lo_nxt         = lo_r;
    len_nxt        = len_r;
    load_ok        = 1'b0;
    load_bad       = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          armed_nxt  = 1'b0;
          period_nxt = '0;
          failed_nxt = 1'b0;
          st_nxt     = S_EMIT;
          unique case (in_type)
            tpg_pkg::REQ_WRITE: ;
            tpg_pkg::REQ_START: begin
              if (cfg.eff_len == '0) begin
                failed_nxt = 1'b1;
              end else begin
                pos_nxt        = '0;
                ear_nxt        = 1'b0;
                phase_nxt      = tpg_pkg::PH_IDLE;
                mask_nxt       = '0;
                pause_nxt      = '0;
                from_start_nxt = 1'b1;
                st_nxt         = S_LOAD;
              end
            end
            tpg_pkg::REQ_STOP: begin
              phase_nxt = tpg_pkg::PH_IDLE;
              run_nxt   = 1'b0;
            end
            tpg_pkg::REQ_EXPIRE: begin
              if (run_r) begin
                priority if (phase_r == tpg_pkg::PH_PAUSE) begin
                  if (pause_r != '0) begin
                    pause_nxt  = pause_r - 16'd1;
                    armed_nxt  = 1'b1;
                    period_nxt = cfg.pilot;
                  end else begin
                    ear_nxt        = 1'b0;
                    from_start_nxt = 1'b0;
                    st_nxt         = S_LOAD;
                  end
                end else if (phase_r != tpg_pkg::PH_IDLE &&
                             phase_r != tpg_pkg::PH_DONE) begin
                  ear_nxt   = ~ear_r;
                  armed_nxt = 1'b1;
                  priority if (phase_r == tpg_pkg::PH_PILOT) begin
                    if (pilot_r > tpg_pkg::PILOT_W'(1)) begin
                      pilot_nxt  = pilot_r - tpg_pkg::PILOT_W'(1);
                      period_nxt = cfg.pilot;
                    end else begin
                      phase_nxt  = tpg_pkg::PH_SYNC1;
                      period_nxt = cfg.sync1;
                    end
                  end else if (phase_r == tpg_pkg::PH_SYNC1) begin
                    phase_nxt  = tpg_pkg::PH_SYNC2;
                    period_nxt = cfg.sync2;
                  end else if (phase_r == tpg_pkg::PH_BIT_A) begin
                    phase_nxt  = tpg_pkg::PH_BIT_B;
                    period_nxt = (|(cur_r & mask_r)) ? cfg.one_bit : cfg.zero_bit;
                  end else begin
                    // sync2 or second bit half: next bit, next byte or pause
                    mask_nxt = mask_sh;
                    if (mask_sh != '0) begin
                      phase_nxt  = tpg_pkg::PH_BIT_A;
                      period_nxt = (|(cur_r & mask_sh)) ? cfg.one_bit : cfg.zero_bit;
                    end else if (bytes_r != '0) begin
                      st_nxt = S_FETCH;
                    end else begin
                      phase_nxt  = tpg_pkg::PH_PAUSE;
                      pause_nxt  = cfg.pause;
                      period_nxt = cfg.pilot;
                    end
                  end
                end else begin
                  armed_nxt = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // room for the two length bytes
      S_LOAD: begin
        if (({1'b0, pos_r} + 18'd2) > {1'b0, cfg.eff_len}) begin
          load_bad = 1'b1;
        end else begin
          st_nxt = S_LEN_LO;
        end
      end

      S_LEN_LO: begin
        lo_nxt = rd_data;
        st_nxt = S_LEN_HI;
      end

      S_LEN_HI: begin
        len_nxt = {rd_data, lo_r};
        pos_nxt = pos_r + LW'(2);
        st_nxt  = S_CHECK;
      end

      // block must fit in the tape
      S_CHECK: begin
        if (({1'b0, pos_r} + 18'(len_r)) > {1'b0, cfg.eff_len}) begin
          load_bad = 1'b1;
        end else begin
          bytes_nxt = len_r;
          mask_nxt  = '0;
          if (len_r != '0) begin
            st_nxt = S_FLAG;
          end else begin
            pilot_nxt = tpg_pkg::DAT_HALVES;
            load_ok   = 1'b1;
          end
        end
      end

      // flag byte picks the pilot length
      S_FLAG: begin
        pilot_nxt = (rd_data == tpg_pkg::FLAG_HDR) ? tpg_pkg::HDR_HALVES :
                                                     tpg_pkg::DAT_HALVES;
        load_ok   = 1'b1;
      end

      // next data byte arrives
      S_FETCH: begin
        cur_nxt    = rd_data;
        pos_nxt    = pos_inc;
        bytes_nxt  = bytes_r - 16'd1;
        mask_nxt   = tpg_pkg::MASK_FIRST;
        phase_nxt  = tpg_pkg::PH_BIT_A;
        period_nxt = rd_data[7] ? cfg.one_bit : cfg.zero_bit;
        st_nxt     = S_EMIT;
      end

      S_EMIT: begin
        if (res_take) begin
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    // outcome of a block load
    if (load_ok) begin
      phase_nxt  = tpg_pkg::PH_PILOT;
      armed_nxt  = 1'b1;
      period_nxt = cfg.pilot;
      if (from_start_r) begin
        run_nxt = 1'b1;
      end
      st_nxt = S_EMIT;
    end
    if (load_bad) begin
      run_nxt = 1'b0;
      if (from_start_r) begin
        failed_nxt = 1'b1;
      end else begin
        phase_nxt = tpg_pkg::PH_DONE;
      end
      st_nxt = S_EMIT;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pos_r   <= '0;
      pilot_r <= '0;
      bytes_r <= '0;
      cur_r   <= '0;
      mask_r  <= '0;
      pause_r <= '0;
      phase_r <= tpg_pkg::PH_IDLE;
      ear_r   <= 1'b0;
      run_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      pos_r   <= pos_nxt;
      pilot_r <= pilot_nxt;
      bytes_r <= bytes_nxt;
      cur_r   <= cur_nxt;
      mask_r  <= mask_nxt;
      pause_r <= pause_nxt;
      phase_r <= phase_nxt;
      ear_r   <= ear_nxt;
      run_r   <= run_nxt;
    end
  end

  // result and scratch payload
  always_ff @(posedge clk) begin
    armed_r      <= armed_nxt;
    period_r     <= period_nxt;
    failed_r     <= failed_nxt;
    from_start_r <= from_start_nxt;
    lo_r         <= lo_nxt;
    len_r        <= len_nxt;
  end

  always_comb begin
    res.ear          = ear_r;
    res.armed        = armed_r;
    res.period       = period_r;
    res.phase        = phase_r;
    res.running      = run_r;
    res.start_failed = failed_r;
  end

endmodule
